// ----- design/slae_pkg.sv -----
// Shared types, constants and helpers for the status LED animation engine.
// Used by slae_phase_div, slae_step and status_led_animation_engine_core.
// No dependencies.
package slae_pkg;

  // mode codes
  localparam logic [2:0] MODE_IDLE       = 3'd0;
  localparam logic [2:0] MODE_LISTENING  = 3'd1;
  localparam logic [2:0] MODE_PROCESSING = 3'd2;
  localparam logic [2:0] MODE_RECORDING  = 3'd3;
  localparam logic [2:0] MODE_UPLOADING  = 3'd4;
  localparam logic [2:0] MODE_SUCCESS    = 3'd5;
  localparam logic [2:0] MODE_ERROR      = 3'd6;
  localparam logic [2:0] MODE_QUEUED     = 3'd7;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MODE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_PULSE_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_FLASH_HALF     = 2'd1;
  localparam logic [1:0] CFG_SUCCESS_LEN    = 2'd2;
  localparam logic [1:0] CFG_ERROR_LEN      = 2'd3;

  // configuration reset values
  localparam logic [7:0]  PULSE_INTERVAL_RST = 8'd20;
  localparam logic [9:0]  FLASH_HALF_RST     = 10'd250;
  localparam logic [11:0] SUCCESS_LEN_RST    = 12'd1500;
  localparam logic [11:0] ERROR_LEN_RST      = 12'd2500;

  // animation constants
  localparam logic [11:0] ELAPSED_MAX  = 12'd4095;
  localparam logic [7:0]  LEVEL_STEP   = 8'd5;
  localparam logic [7:0]  LEVEL_TOP    = 8'd250;
  localparam logic [7:0]  LEVEL_BOTTOM = 8'd5;

  // restoring division steps for a 12-bit elapsed count
  localparam logic [3:0] DIV_STEPS = 4'd12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t       colour;
    logic [2:0] mode_now;
    logic       refresh;
  } result_t;

  // flash phase realignment after a flash half write
  typedef struct packed {
    logic       load;
    logic [9:0] rem;
    logic       odd;
  } phase_load_t;

  // base colour of each mode
  function automatic rgb_t base_colour(input logic [2:0] mode);
    rgb_t c;
    case (mode)
      MODE_IDLE:       c = '{8'd0,   8'd255, 8'd0};
      MODE_LISTENING:  c = '{8'd0,   8'd0,   8'd255};
      MODE_PROCESSING: c = '{8'd255, 8'd200, 8'd0};
      MODE_RECORDING:  c = '{8'd255, 8'd0,   8'd0};
      MODE_UPLOADING:  c = '{8'd0,   8'd255, 8'd255};
      MODE_SUCCESS:    c = '{8'd0,   8'd255, 8'd0};
      MODE_ERROR:      c = '{8'd255, 8'd0,   8'd0};
      MODE_QUEUED:     c = '{8'd255, 8'd100, 8'd0};
      default:         c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

  // base * level / 255, exact for products below 65535
  function automatic logic [7:0] scale_chan(input logic [7:0] base, input logic [7:0] lvl);
    logic [15:0] p;
    logic [16:0] s;
    p = base * lvl;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ----- design/slae_phase_div.sv -----
// Iterative divider that realigns the flash phase after a flash half write.
// Divides the elapsed count by the new half length, one quotient bit a cycle.
// Depends on slae_pkg.
module slae_phase_div
  import slae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [9:0]  half_i,
  input  logic [11:0] elapsed_i,
  output logic        busy_o,
  output phase_load_t load_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic [11:0] dvd_q, dvd_d;
  logic [9:0]  rem_q, rem_d;
  logic [9:0]  div_q, div_d;
  logic [10:0] rem_shift;
  logic        ge;
  logic [9:0]  rem_next;

  // one restoring step; the remainder stays below the divisor
  always_comb begin
    rem_shift = {rem_q, dvd_q[11]};
    ge        = rem_shift >= {1'b0, div_q};
    rem_next  = ge ? 10'(rem_shift - {1'b0, div_q}) : rem_shift[9:0];
  end

  // load, step or hold
  always_comb begin
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    div_d = div_q;
    if (start_i) begin
      cnt_d = DIV_STEPS;
      dvd_d = elapsed_i;
      rem_d = '0;
      div_d = (half_i == 10'd0) ? 10'd1 : half_i;
    end else if (cnt_q != 4'd0) begin
      cnt_d = cnt_q - 4'd1;
      dvd_d = {dvd_q[10:0], 1'b0};
      rem_d = rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // hand the final remainder and quotient parity over on the last step
  assign busy_o      = cnt_q != 4'd0;
  assign load_o.load = (cnt_q == 4'd1) && !start_i;
  assign load_o.rem  = rem_next;
  assign load_o.odd  = ge;

endmodule

// ----- design/slae_step.sv -----
// Animation state and the single-pass update for one input word.
// Holds mode, elapsed count, level, direction, shown colour and flash phase.
// Depends on slae_pkg.
module slae_step
  import slae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        command_i,
  input  logic [2:0]  new_mode_i,
  input  logic [7:0]  pulse_interval_i,
  input  logic [9:0]  flash_half_i,
  input  logic [11:0] success_len_i,
  input  logic [11:0] error_len_i,
  input  phase_load_t phase_load_i,
  output logic [11:0] elapsed_o,
  output result_t     result_o
);

  logic [2:0]  mode_q, mode_d;
  logic [11:0] elapsed_q, elapsed_d;
  logic [7:0]  level_q, level_d;
  logic        rising_q, rising_d;
  rgb_t        shown_q, shown_d;
  logic [9:0]  rem_q, rem_d;
  logic        odd_q, odd_d;
  logic        refresh;

  logic [11:0] el_inc;
  logic [9:0]  rem_inc;
  logic        odd_inc;
  logic [9:0]  half_eff;
  logic [11:0] flash_len;
  logic [7:0]  lvl_next;
  logic        rising_next;
  rgb_t        base;

  // saturating count with its flash phase carried along
  always_comb begin
    half_eff = (flash_half_i == 10'd0) ? 10'd1 : flash_half_i;
    el_inc   = elapsed_q;
    rem_inc  = rem_q;
    odd_inc  = odd_q;
    if (elapsed_q != ELAPSED_MAX) begin
      el_inc = elapsed_q + 12'd1;
      if (({1'b0, rem_q} + 11'd1) == {1'b0, half_eff}) begin
        rem_inc = '0;
        odd_inc = !odd_q;
      end else begin
        rem_inc = rem_q + 10'd1;
      end
    end
  end

  // triangle level step
  always_comb begin
    rising_next = rising_q;
    if (rising_q) begin
      lvl_next = level_q + LEVEL_STEP;
      if (lvl_next >= LEVEL_TOP) rising_next = 1'b0;
    end else begin
      lvl_next = level_q - LEVEL_STEP;
      if (lvl_next <= LEVEL_BOTTOM) rising_next = 1'b1;
    end
  end

  assign base      = base_colour(mode_q);
  assign flash_len = (mode_q == MODE_SUCCESS) ? success_len_i : error_len_i;

  // next state for a tick or a mode change
  always_comb begin
    mode_d    = mode_q;
    elapsed_d = elapsed_q;
    level_d   = level_q;
    rising_d  = rising_q;
    shown_d   = shown_q;
    rem_d     = rem_q;
    odd_d     = odd_q;
    refresh   = 1'b0;
    if (phase_load_i.load) begin
      rem_d = phase_load_i.rem;
      odd_d = phase_load_i.odd;
    end else if (fire_i) begin
      if (command_i == CMD_MODE) begin
        if (new_mode_i != mode_q) begin
          mode_d    = new_mode_i;
          elapsed_d = '0;
          level_d   = '0;
          rising_d  = 1'b1;
          rem_d     = '0;
          odd_d     = 1'b0;
        end
      end else begin
        case (mode_q)
          MODE_PROCESSING: begin
            elapsed_d = el_inc;
            rem_d     = rem_inc;
            odd_d     = odd_inc;
            shown_d   = base;
            refresh   = 1'b1;
          end
          MODE_SUCCESS, MODE_ERROR: begin
            if (el_inc < flash_len) begin
              elapsed_d = el_inc;
              rem_d     = rem_inc;
              odd_d     = odd_inc;
              shown_d   = odd_inc ? base : '0;
              refresh   = 1'b1;
            end else begin
              // flashing done: drop back to idle
              mode_d    = MODE_IDLE;
              elapsed_d = '0;
              level_d   = '0;
              rising_d  = 1'b1;
              rem_d     = '0;
              odd_d     = 1'b0;
            end
          end
          default: begin
            if (el_inc > {4'd0, pulse_interval_i}) begin
              elapsed_d     = '0;
              rem_d         = '0;
              odd_d         = 1'b0;
              level_d       = lvl_next;
              rising_d      = rising_next;
              shown_d.red   = scale_chan(base.red, lvl_next);
              shown_d.green = scale_chan(base.green, lvl_next);
              shown_d.blue  = scale_chan(base.blue, lvl_next);
              refresh       = 1'b1;
            end else begin
              elapsed_d = el_inc;
              rem_d     = rem_inc;
              odd_d     = odd_inc;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      elapsed_q <= '0;
      level_q   <= '0;
      rising_q  <= 1'b1;
      shown_q   <= '0;
      rem_q     <= '0;
      odd_q     <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      level_q   <= level_d;
      rising_q  <= rising_d;
      shown_q   <= shown_d;
      rem_q     <= rem_d;
      odd_q     <= odd_d;
    end
  end

  assign elapsed_o         = elapsed_q;
  assign result_o.colour   = shown_d;
  assign result_o.mode_now = mode_d;
  assign result_o.refresh  = refresh;

endmodule

// ----- design/status_led_animation_engine_core.sv -----
// Status LED animation engine: one RGB result word for each input word.
// Accepted words pass through the input register, then the result register.
// One word per cycle unless stalled; the update path is a single pass of logic.
// A flash half write stalls input while the flash phase is realigned
// by the iterative divider. Reset (rst_ni low, asynchronous) restores idle mode and
// the register defaults; results appear only after reset is released.
module status_led_animation_engine_core
  import slae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [2:0]  new_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [2:0]  mode_now_o,
  output logic        refresh_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  logic [7:0]  pulse_interval_q;
  logic [9:0]  flash_half_q;
  logic [11:0] success_len_q;
  logic [11:0] error_len_q;

  logic        in_v_q;
  logic        in_cmd_q;
  logic [2:0]  in_mode_q;
  logic        out_v_q;
  result_t     out_q;

  logic        fire;
  logic        in_take;
  logic        div_busy;
  logic        div_start;
  logic [11:0] elapsed;
  phase_load_t phase_load;
  result_t     result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_interval_q <= PULSE_INTERVAL_RST;
      flash_half_q     <= FLASH_HALF_RST;
      success_len_q    <= SUCCESS_LEN_RST;
      error_len_q      <= ERROR_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PULSE_INTERVAL: pulse_interval_q <= cfg_data_i[7:0];
        CFG_FLASH_HALF:     flash_half_q     <= cfg_data_i[9:0];
        CFG_SUCCESS_LEN:    success_len_q    <= cfg_data_i;
        CFG_ERROR_LEN:      error_len_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign div_start = cfg_we_i && (cfg_index_i == CFG_FLASH_HALF);

  // handshake: advance when the result register is free or being taken
  assign fire       = in_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = div_busy || (in_v_q && !fire);
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_take) begin
      in_v_q <= 1'b1;
    end else if (fire) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q  <= command_i;
      in_mode_q <= new_mode_i;
    end
  end

  slae_phase_div u_phase_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .half_i    (cfg_data_i[9:0]),
    .elapsed_i (elapsed),
    .busy_o    (div_busy),
    .load_o    (phase_load)
  );

  slae_step u_step (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .command_i        (in_cmd_q),
    .new_mode_i       (in_mode_q),
    .pulse_interval_i (pulse_interval_q),
    .flash_half_i     (flash_half_q),
    .success_len_i    (success_len_q),
    .error_len_i      (error_len_q),
    .phase_load_i     (phase_load),
    .elapsed_o        (elapsed),
    .result_o         (result)
  );

  // result register: hold while stalled, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_v_q;
  assign red_o       = out_q.colour.red;
  assign green_o     = out_q.colour.green;
  assign blue_o      = out_q.colour.blue;
  assign mode_now_o  = out_q.mode_now;
  assign refresh_o   = out_q.refresh;

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for status_led_animation_engine_core: a directed table, then random
// words with bursty input and a stalling receiver, checked against an in-bench LED model.
// Depends on slae_pkg and the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slae_pkg::*;

  localparam int PLAN_ROWS    = 33;
  localparam int RANDOM_WORDS = 1900;
  localparam int PHASE_WORDS  = 160;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_CAP   = 40;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_e;

  typedef struct packed {
    row_kind_e  kind;
    logic       cmd;
    logic [2:0] mode;
    logic [1:0] reg_idx;
    logic [11:0] reg_val;
    logic       typed;
    result_t    want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [2:0]  new_mode_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [2:0]  mode_now_o;
  logic        refresh_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [11:0] cfg_data_i;

  // LED model: registers and animation state
  logic [7:0]  pulse_ivl;
  logic [9:0]  half_ms;
  logic [11:0] succ_len;
  logic [11:0] err_len;
  logic [2:0]  anim_mode;
  logic [11:0] since_ms;
  logic [7:0]  bright;
  logic        going_up;
  rgb_t        lit;

  result_t     led_due [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int          burst_left = 0;
  logic        offering = 1'b0;
  logic        hold_req = 1'b0;

  // receiver pattern state
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          seg_left = 0;
  stall_style_e style = STALL_NONE;

  status_led_animation_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .new_mode_i  (new_mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .mode_now_o  (mode_now_o),
    .refresh_o   (refresh_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // full-scale colour of each mode
  function automatic rgb_t hue_of(input logic [2:0] m);
    case (m)
      MODE_IDLE, MODE_SUCCESS:  return 24'h00FF00;
      MODE_LISTENING:           return 24'h0000FF;
      MODE_PROCESSING:          return 24'hFFC800;
      MODE_RECORDING, MODE_ERROR: return 24'hFF0000;
      MODE_UPLOADING:           return 24'h00FFFF;
      default:                  return 24'hFF6400;
    endcase
  endfunction

  // scale one channel by brightness/255, rounding down
  function automatic logic [7:0] dim(input logic [7:0] b, input logic [7:0] l);
    int p;
    p = int'(b) * int'(l);
    return 8'(p / 255);
  endfunction

  task automatic reset_model();
    pulse_ivl = PULSE_INTERVAL_RST;
    half_ms   = FLASH_HALF_RST;
    succ_len  = SUCCESS_LEN_RST;
    err_len   = ERROR_LEN_RST;
    anim_mode = MODE_IDLE;
    since_ms  = '0;
    bright    = '0;
    going_up  = 1'b1;
    lit       = '0;
  endtask

  // a change to another mode restarts the animation; the same mode is left alone
  task automatic enter_mode(input logic [2:0] m);
    if (m != anim_mode) begin
      anim_mode = m;
      bright    = '0;
      going_up  = 1'b1;
      since_ms  = '0;
    end
  endtask

  task automatic predict_led(input logic cmd, input logic [2:0] m, output result_t res);
    logic        refresh;
    logic [11:0] len;
    logic [9:0]  half;
    rgb_t        hue;
    refresh = 1'b0;
    if (cmd == CMD_MODE) begin
      enter_mode(m);
    end else begin
      // advance the millisecond count first, holding at full scale
      if (since_ms != '1) since_ms++;
      case (anim_mode)
        MODE_PROCESSING: begin
          lit     = hue_of(MODE_PROCESSING);
          refresh = 1'b1;
        end
        MODE_SUCCESS, MODE_ERROR: begin
          len  = (anim_mode == MODE_SUCCESS) ? succ_len : err_len;
          half = (half_ms == '0) ? 10'd1 : half_ms;
          if (since_ms < len) begin
            lit     = (((since_ms / half) & 12'd1) != '0) ? hue_of(anim_mode) : rgb_t'('0);
            refresh = 1'b1;
          end else begin
            enter_mode(MODE_IDLE);
          end
        end
        default: begin
          // step the triangle once the interval has passed
          if (since_ms > pulse_ivl) begin
            since_ms = '0;
            if (going_up) begin
              bright = bright + 8'd5;
              if (bright >= 8'd250) going_up = 1'b0;
            end else begin
              bright = bright - 8'd5;
              if (bright <= 8'd5) going_up = 1'b1;
            end
            hue     = hue_of(anim_mode);
            lit     = {dim(hue.red, bright), dim(hue.green, bright), dim(hue.blue, bright)};
            refresh = 1'b1;
          end
        end
      endcase
    end
    res = {lit, anim_mode, refresh};
  endtask

  function automatic row_t word_row(input logic cmd, input logic [2:0] m, input logic typed,
                                    input result_t want);
    return {ROW_WORD, cmd, m, CFG_PULSE_INTERVAL, 12'h000, typed, want};
  endfunction

  function automatic row_t reg_row(input logic [1:0] idx, input logic [11:0] val);
    return {ROW_REG, CMD_TICK, MODE_IDLE, idx, val, 1'b0, 28'd0};
  endfunction

  // directed table: defaults, then zero and wide register values, then the extremes
  function automatic row_t plan_row(input int n);
    case (n)
      0:  return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h000000, MODE_IDLE, 1'b0});
      1:  return word_row(CMD_MODE, MODE_PROCESSING, 1'b1, {24'h000000, MODE_PROCESSING, 1'b0});
      2:  return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'hFFC800, MODE_PROCESSING, 1'b1});
      3:  return word_row(CMD_MODE, MODE_PROCESSING, 1'b1, {24'hFFC800, MODE_PROCESSING, 1'b0});
      4:  return word_row(CMD_MODE, MODE_SUCCESS, 1'b1, {24'hFFC800, MODE_SUCCESS, 1'b0});
      5:  return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h000000, MODE_SUCCESS, 1'b1});
      6:  return word_row(CMD_MODE, MODE_ERROR, 1'b1, {24'h000000, MODE_ERROR, 1'b0});
      7:  return reg_row(CFG_PULSE_INTERVAL, 12'hF00);
      8:  return reg_row(CFG_FLASH_HALF, 12'hC00);
      9:  return reg_row(CFG_SUCCESS_LEN, 12'h000);
      10: return reg_row(CFG_ERROR_LEN, 12'hFFF);
      11: return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'hFF0000, MODE_ERROR, 1'b1});
      12: return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h000000, MODE_ERROR, 1'b1});
      13: return word_row(CMD_MODE, MODE_SUCCESS, 1'b1, {24'h000000, MODE_SUCCESS, 1'b0});
      14: return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h000000, MODE_IDLE, 1'b0});
      15: return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h000500, MODE_IDLE, 1'b1});
      16: return word_row(CMD_MODE, MODE_QUEUED, 1'b1, {24'h000500, MODE_QUEUED, 1'b0});
      17: return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h050100, MODE_QUEUED, 1'b1});
      18: return word_row(CMD_MODE, MODE_LISTENING, 1'b0, 28'd0);
      19: return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h000005, MODE_LISTENING, 1'b1});
      20: return word_row(CMD_MODE, MODE_RECORDING, 1'b0, 28'd0);
      21: return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h050000, MODE_RECORDING, 1'b1});
      22: return word_row(CMD_MODE, MODE_UPLOADING, 1'b0, 28'd0);
      23: return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h000505, MODE_UPLOADING, 1'b1});
      24: return reg_row(CFG_PULSE_INTERVAL, 12'hEFF);
      25: return reg_row(CFG_FLASH_HALF, 12'h3FF);
      26: return reg_row(CFG_SUCCESS_LEN, 12'hFFF);
      27: return reg_row(CFG_ERROR_LEN, 12'h001);
      28: return word_row(CMD_MODE, MODE_ERROR, 1'b1, {24'h000505, MODE_ERROR, 1'b0});
      29: return word_row(CMD_TICK, MODE_IDLE, 1'b1, {24'h000505, MODE_IDLE, 1'b0});
      30: return word_row(CMD_TICK, MODE_QUEUED, 1'b1, {24'h000505, MODE_IDLE, 1'b0});
      31: return word_row(CMD_MODE, MODE_IDLE, 1'b1, {24'h000505, MODE_IDLE, 1'b0});
      default: return word_row(CMD_MODE, MODE_QUEUED, 1'b1, {24'h000505, MODE_QUEUED, 1'b0});
    endcase
  endfunction

  // offer one word in bursts with random gaps, then log what it should show
  task automatic offer_word(input logic cmd, input logic [2:0] m, input logic typed,
                            input result_t want);
    result_t guess;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0 && offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    new_mode_i <= m;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    burst_left--;
    words_sent++;
    predict_led(cmd, m, guess);
    led_due.push_back(typed ? want : guess);
  endtask

  // drop valid and let every outstanding word come back
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    offering = 1'b0;
    while (led_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_PULSE_INTERVAL: pulse_ivl = val[7:0];
      CFG_FLASH_HALF:     half_ms   = val[9:0];
      CFG_SUCCESS_LEN:    succ_len  = val;
      CFG_ERROR_LEN:      err_len   = val;
      default: ;
    endcase
  endtask

  // flash length: mostly short so the fall back to idle happens often
  function automatic logic [11:0] flash_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return 12'($urandom_range(0, 80));
      7:                   return 12'hFFF;
      8:                   return 12'd1;
      default:             return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic shuffle_registers();
    logic [11:0] v;
    drain_pipeline();
    // pulse interval: mostly short so runs of ticks reach both ends of the triangle
    v = 12'($urandom_range(0, 4095));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v[7:0] = 8'($urandom_range(0, 3));
      6, 7:             v[7:0] = 8'($urandom_range(4, 20));
      8:                v[7:0] = 8'hFF;
      default: ;
    endcase
    write_reg(CFG_PULSE_INTERVAL, v);
    // flash half: short halves give many on and off flips
    v = 12'($urandom_range(0, 4095));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: v[9:0] = 10'($urandom_range(0, 6));
      7:                   v[9:0] = 10'h3FF;
      8:                   v[9:0] = 10'd1;
      default: ;
    endcase
    write_reg(CFG_FLASH_HALF, v);
    write_reg(CFG_SUCCESS_LEN, flash_length());
    write_reg(CFG_ERROR_LEN, flash_length());
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (mismatches < REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare each delivered word with the oldest one due
  always @(posedge clk_i) begin : check_word
    result_t due;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (led_due.size() == 0) begin
        if (mismatches < REPORT_CAP) $error("result word arrived with nothing due");
        mismatches++;
      end else begin
        due = led_due.pop_front();
        check_field("red", due.colour.red, red_o);
        check_field("green", due.colour.green, green_o);
        check_field("blue", due.colour.blue, blue_o);
        check_field("mode_now", {5'd0, due.mode_now}, {5'd0, mode_now_o});
        check_field("refresh", {7'd0, due.refresh}, {7'd0, refresh_o});
      end
    end
  end

  // receiver: segments of differing stall density, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        style    = stall_style_e'($urandom_range(0, 3));
        seg_left = $urandom_range(5, 60);
      end
      seg_left--;
      case (style)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t        r;
    logic [2:0]  m;
    int unsigned phase_start;
    int          run;
    int          phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    command_i   = CMD_TICK;
    new_mode_i  = MODE_IDLE;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_PULSE_INTERVAL;
    cfg_data_i  = '0;
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table
    for (int n = 0; n < PLAN_ROWS; n++) begin
      r = plan_row(n);
      if (r.kind == ROW_REG) begin
        drain_pipeline();
        write_reg(r.reg_idx, r.reg_val);
      end else begin
        offer_word(r.cmd, r.mode, r.typed, r.want);
      end
    end

    // random phases: mostly a mode change followed by a run of ticks, some noise
    words_sent = 0;
    for (phase = 0; words_sent < RANDOM_WORDS; phase++) begin
      shuffle_registers();
      if (phase == 3) hold_req <= 1'b1;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS && words_sent < RANDOM_WORDS) begin
        if ($urandom_range(0, 6) != 0) begin
          m = 3'($urandom_range(0, 7));
          offer_word(CMD_MODE, m, 1'b0, '0);
          run = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 220) : $urandom_range(1, 60);
          repeat (run) begin
            if (words_sent < RANDOM_WORDS) begin
              m = 3'($urandom_range(0, 7));
              offer_word(CMD_TICK, m, 1'b0, '0);
            end
          end
        end else begin
          m = 3'($urandom_range(0, 7));
          offer_word(($urandom_range(0, 1) == 1) ? CMD_MODE : CMD_TICK, m, 1'b0, '0);
        end
      end
    end

    drain_pipeline();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- status_led_animation_engine_core.f -----
design/slae_pkg.sv
design/slae_phase_div.sv
design/slae_step.sv
design/status_led_animation_engine_core.sv
tb/tb.sv
